// ===== sv/ual_pkg.sv =====
// ----------------------------------------------------------------------------
// ual_pkg
// Shared types and constants for the unordered array list engine.
// ----------------------------------------------------------------------------
package ual_pkg;

  localparam int DEPTH      = 64;
  localparam int ITEM_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int FOUND_W    = ADDR_W + 1;
  localparam int LIMIT_W    = 7;
  localparam int OP_W       = 3;
  localparam int VALUE_W    = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT_AT    = 3'd0,
    OP_INSERT_END   = 3'd1,
    OP_INSERT_FIRST = 3'd2,
    OP_REPLACE      = 3'd3,
    OP_REMOVE       = 3'd4,
    OP_SEARCH       = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_ZERO,
    RD_LAST
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ITEM_POS,
    WR_ITEM_END,
    WR_ITEM_ZERO,
    WR_DATA_END,
    WR_DATA_POS
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    shift_step;
    logic    scan_step;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    fin;
    status_t fin_status;
    logic    count_inc;
    logic    count_dec;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic range_ins;
    logic range_pos;
    logic full;
    logic empty;
    logic shift_more;
    logic pend;
    logic match;
    logic scan_end;
  } dp_stat_t;

endpackage

// ===== sv/ual_ram.sv =====
// ----------------------------------------------------------------------------
// ual_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ual_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/ual_dp.sv =====
// ----------------------------------------------------------------------------
// ual_dp
// Datapath: request registers, list length, limit register, walk pointer,
// entry memory and result registers.
// ----------------------------------------------------------------------------
module ual_dp import ual_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [LIMIT_W-1:0] cfg_data,
  input  logic [OP_W-1:0]    operation,
  input  logic [ADDR_W-1:0]  position,
  input  logic [VALUE_W-1:0] item_value,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic               done,
  output logic [1:0]         status,
  output logic [FOUND_W-1:0] found_index,
  output logic [CNT_W-1:0]   entry_count
);

  logic [LIMIT_W-1:0]    list_limit;
  op_t                   op_q;
  logic [ADDR_W-1:0]     pos_q;
  logic [ITEM_WIDTH-1:0] item_q;
  logic [CNT_W-1:0]      count_q;
  logic [CNT_W-1:0]      ptr;
  logic [ADDR_W-1:0]     tag;
  logic                  pend;

  logic [CNT_W-1:0]      limit_eff;
  logic [CNT_W-1:0]      pos_ext;
  logic [CNT_W-1:0]      ptr_dec;
  logic [CNT_W-1:0]      last_idx;
  logic [CNT_W-1:0]      count_next;
  logic                  scan_more;

  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ITEM_WIDTH-1:0] rd_data;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ITEM_WIDTH-1:0] wr_data;

  assign limit_eff  = (list_limit > LIMIT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(list_limit);
  assign pos_ext    = CNT_W'(pos_q);
  assign ptr_dec    = ptr - CNT_W'(1);
  assign last_idx   = count_q - CNT_W'(1);
  assign scan_more  = ptr < count_q;
  assign count_next = count_q + CNT_W'(cmd.count_inc) - CNT_W'(cmd.count_dec);

  always_comb begin
    stat.op         = op_q;
    stat.range_ins  = (pos_ext >= limit_eff) || (pos_ext > count_q);
    stat.range_pos  = pos_ext >= count_q;
    stat.full       = count_q >= limit_eff;
    stat.empty      = count_q == '0;
    stat.shift_more = ptr != pos_ext;
    stat.pend       = pend;
    stat.match      = pend && (rd_data == item_q);
    stat.scan_end   = ptr == count_q;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.shift_step && stat.shift_more) begin
      rd_en   = 1'b1;
      rd_addr = ptr_dec[ADDR_W-1:0];
    end else if (cmd.scan_step && scan_more) begin
      rd_en   = 1'b1;
      rd_addr = ptr[ADDR_W-1:0];
    end else begin
      case (cmd.rd_sel)
        RD_ZERO: begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
        RD_LAST: begin
          rd_en   = 1'b1;
          rd_addr = last_idx[ADDR_W-1:0];
        end
        default: begin
          rd_en   = 1'b0;
          rd_addr = '0;
        end
      endcase
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = item_q;
    if (cmd.shift_step && pend) begin
      wr_en   = 1'b1;
      wr_addr = tag;
      wr_data = rd_data;
    end else begin
      case (cmd.wr_sel)
        WR_ITEM_POS: begin
          wr_en   = 1'b1;
          wr_addr = pos_q;
        end
        WR_ITEM_END: begin
          wr_en   = 1'b1;
          wr_addr = count_q[ADDR_W-1:0];
        end
        WR_ITEM_ZERO: begin
          wr_en   = 1'b1;
          wr_addr = '0;
        end
        WR_DATA_END: begin
          wr_en   = 1'b1;
          wr_addr = count_q[ADDR_W-1:0];
          wr_data = rd_data;
        end
        WR_DATA_POS: begin
          wr_en   = 1'b1;
          wr_addr = pos_q;
          wr_data = rd_data;
        end
        default: begin
          wr_en   = 1'b0;
        end
      endcase
    end
  end

  ual_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      list_limit <= LIMIT_W'(DEPTH);
      count_q    <= '0;
      pend       <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= cmd.fin;
      if (cfg_valid) begin
        list_limit <= cfg_data;
      end
      if (cmd.load) begin
        pend <= 1'b0;
      end else if (cmd.shift_step) begin
        pend <= stat.shift_more;
      end else if (cmd.scan_step) begin
        pend <= scan_more;
      end
      if (cmd.fin) begin
        count_q <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op_t'(operation);
      pos_q  <= position;
      item_q <= item_value[ITEM_WIDTH-1:0];
      ptr    <= (op_t'(operation) == OP_SEARCH) ? '0 : count_q;
    end else if (cmd.shift_step && stat.shift_more) begin
      ptr <= ptr_dec;
      tag <= ptr[ADDR_W-1:0];
    end else if (cmd.scan_step && scan_more) begin
      ptr <= ptr + CNT_W'(1);
      tag <= ptr[ADDR_W-1:0];
    end
    if (cmd.fin) begin
      status      <= cmd.fin_status;
      entry_count <= count_next;
      found_index <= (cmd.scan_step && stat.match) ? {1'b0, tag} : '1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_q <= CNT_W'(DEPTH))
    else $error("List length exceeds the storage depth.");

  a_count_moves_on_fin: assert property (@(posedge clk) disable iff (rst)
    !cmd.fin |=> $stable(count_q))
    else $error("List length changed without a finished request.");

endmodule

// ===== sv/ual_ctrl.sv =====
// ----------------------------------------------------------------------------
// ual_ctrl
// Controller: sequences each request over the datapath and its memory.
// ----------------------------------------------------------------------------
module ual_ctrl import ual_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT,
    S_FIRST_MOVE,
    S_FIRST_PUT,
    S_REM_MOVE,
    S_SCAN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_NONE;
    cmd.wr_sel = WR_NONE;
    cmd.fin_status = ST_DONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.op)
          OP_INSERT_AT: begin
            if (stat.range_ins) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = ST_RANGE;
              state_next     = S_IDLE;
            end else if (stat.full) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = ST_FULL;
              state_next     = S_IDLE;
            end else begin
              state_next = S_SHIFT;
            end
          end
          OP_INSERT_END: begin
            cmd.fin    = 1'b1;
            state_next = S_IDLE;
            if (stat.full) begin
              cmd.fin_status = ST_FULL;
            end else begin
              cmd.wr_sel    = WR_ITEM_END;
              cmd.count_inc = 1'b1;
            end
          end
          OP_INSERT_FIRST: begin
            if (stat.full) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = ST_FULL;
              state_next     = S_IDLE;
            end else if (stat.empty) begin
              cmd.wr_sel    = WR_ITEM_END;
              cmd.count_inc = 1'b1;
              cmd.fin       = 1'b1;
              state_next    = S_IDLE;
            end else begin
              cmd.rd_sel = RD_ZERO;
              state_next = S_FIRST_MOVE;
            end
          end
          OP_REPLACE: begin
            cmd.fin    = 1'b1;
            state_next = S_IDLE;
            if (stat.range_pos) begin
              cmd.fin_status = ST_RANGE;
            end else begin
              cmd.wr_sel = WR_ITEM_POS;
            end
          end
          OP_REMOVE: begin
            if (stat.range_pos) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = ST_RANGE;
              state_next     = S_IDLE;
            end else begin
              cmd.rd_sel = RD_LAST;
              state_next = S_REM_MOVE;
            end
          end
          OP_SEARCH: begin
            state_next = S_SCAN;
          end
          default: begin
            cmd.fin    = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_SHIFT: begin
        if (!stat.shift_more && !stat.pend) begin
          cmd.wr_sel    = WR_ITEM_POS;
          cmd.count_inc = 1'b1;
          cmd.fin       = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_FIRST_MOVE: begin
        cmd.wr_sel = WR_DATA_END;
        state_next = S_FIRST_PUT;
      end
      S_FIRST_PUT: begin
        cmd.wr_sel    = WR_ITEM_ZERO;
        cmd.count_inc = 1'b1;
        cmd.fin       = 1'b1;
        state_next    = S_IDLE;
      end
      S_REM_MOVE: begin
        cmd.wr_sel    = WR_DATA_POS;
        cmd.count_dec = 1'b1;
        cmd.fin       = 1'b1;
        state_next    = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.match || (!stat.pend && stat.scan_end)) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= state_next != S_IDLE;
    end
  end

endmodule

// ===== sv/unordered_array_list_engine.sv =====
// ----------------------------------------------------------------------------
// unordered_array_list_engine
// Bounded list of signed items with insert, replace, remove and search.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result is
// shown for a single cycle with done high and must be captured then, since
// the block cannot be stalled. The entries sit in a memory with one read and
// one write port that moves one entry per cycle. Insert end, replace and
// rejected requests finish in the decode state, as does insert first on an
// empty list; remove copies the last entry to the position; insert first
// moves entry 0 to the end and then writes the item at 0; insert at shifts
// the entries above the position up one by one; search walks from entry 0.
// The limit register may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module unordered_array_list_engine import ual_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    operation,
  input  logic [ADDR_W-1:0]  position,
  input  logic [VALUE_W-1:0] item_value,
  output logic               done,
  output logic [1:0]         status,
  output logic [FOUND_W-1:0] found_index,
  output logic [CNT_W-1:0]   entry_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  ual_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ual_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .operation   (operation),
    .position    (position),
    .item_value  (item_value),
    .cmd         (cmd),
    .stat        (stat),
    .done        (done),
    .status      (status),
    .found_index (found_index),
    .entry_count (entry_count)
  );

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("Result strobe without a request in progress.");

  a_request_holds_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Accepted request did not raise busy.");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the unordered array list engine.
// ----------------------------------------------------------------------------
// Requests are sent through the start/busy handshake and the list is
// tracked in a local copy that predicts status, match index and length for
// each request. Every done strobe is checked against the oldest prediction.
// Directed requests cover the empty, full and out-of-range cases and the
// limit corners. Random phases then grow and shrink the list under several
// limits, with random sender gaps in most phases.
// ----------------------------------------------------------------------------
module tb_top;
  import ual_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD_A   = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_B   = 3'd7;
  localparam int              CYCLE_LIMIT = 1_000_000;
  localparam int              MAX_REPORTS = 10;

  typedef struct packed {
    status_t            st;
    logic [FOUND_W-1:0] idx;
    logic [CNT_W-1:0]   cnt;
  } list_result_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [OP_W-1:0]    operation;
  logic [ADDR_W-1:0]  position;
  logic [VALUE_W-1:0] item_value;
  logic               done;
  logic [1:0]         status;
  logic [FOUND_W-1:0] found_index;
  logic [CNT_W-1:0]   entry_count;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;

  logic [VALUE_W-1:0] list_mem [DEPTH];
  int                 list_len;
  logic [LIMIT_W-1:0] list_limit_q;
  list_result_t       pending_results [$];
  list_result_t       head;
  int                 error_count;
  int                 cycle_count;
  bit                 gaps_on;

  unordered_array_list_engine u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .position    (position),
    .item_value  (item_value),
    .done        (done),
    .status      (status),
    .found_index (found_index),
    .entry_count (entry_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic list_result_t apply_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] pos,
                                                 logic [VALUE_W-1:0] val);
    list_result_t r;
    int           lim;
    int           p;
    int           i;
    bit           hit;
    lim   = (list_limit_q > DEPTH) ? DEPTH : int'(list_limit_q);
    p     = int'(pos);
    hit   = 1'b0;
    r.st  = ST_DONE;
    r.idx = '1;
    case (op)
      OP_INSERT_AT: begin
        if (p >= lim || p > list_len) begin
          r.st = ST_RANGE;
        end else if (list_len >= lim) begin
          r.st = ST_FULL;
        end else begin
          for (i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = val;
          list_len++;
        end
      end
      OP_INSERT_END: begin
        if (list_len >= lim) begin
          r.st = ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      OP_INSERT_FIRST: begin
        if (list_len >= lim) begin
          r.st = ST_FULL;
        end else begin
          list_mem[list_len] = list_mem[0];
          list_mem[0] = val;
          list_len++;
        end
      end
      OP_REPLACE: begin
        if (p >= list_len) r.st = ST_RANGE;
        else list_mem[p] = val;
      end
      OP_REMOVE: begin
        if (p >= list_len) begin
          r.st = ST_RANGE;
        end else begin
          list_mem[p] = list_mem[list_len-1];
          list_len--;
        end
      end
      OP_SEARCH: begin
        for (i = 0; i < list_len && !hit; i++) begin
          if (list_mem[i] == val) begin
            r.idx = FOUND_W'(i);
            hit   = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.cnt = CNT_W'(list_len);
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch at %0t, %s: expected %0h, got %0h", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with no request pending", 32'd0, 32'd1);
      end else begin
        head = pending_results.pop_front();
        if (status !== head.st) note_mismatch("status", 32'(head.st), 32'(status));
        if (found_index !== head.idx)
          note_mismatch("found_index", 32'(head.idx), 32'(found_index));
        if (entry_count !== head.cnt)
          note_mismatch("entry_count", 32'(head.cnt), 32'(entry_count));
      end
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] pos,
                              input logic [VALUE_W-1:0] val);
    int gap;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    operation  <= op;
    position   <= pos;
    item_value <= val;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_request(op, pos, val));
  endtask

  task automatic drain_requests();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    drain_requests();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    list_limit_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      case ($urandom_range(0, 3))
        0:       return 32'h0000_0005;
        1:       return 32'hFFFF_FFFB;
        2:       return 32'h1234_5678;
        default: return 32'hA5A5_A5A5;
      endcase
    end
    if (r == 3) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  task automatic random_request(input int insert_w, input int remove_w);
    int                 r;
    int                 top;
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  pos;
    logic [VALUE_W-1:0] val;
    r = $urandom_range(0, 99);
    if (r < insert_w) op = OP_W'($urandom_range(OP_INSERT_AT, OP_INSERT_FIRST));
    else if (r < insert_w + remove_w) op = OP_REMOVE;
    else if (r < insert_w + remove_w + 12) op = OP_REPLACE;
    else if (r < 98) op = OP_SEARCH;
    else op = ($urandom_range(0, 1) == 0) ? OP_RSVD_A : OP_RSVD_B;
    top = (list_len > DEPTH - 1) ? DEPTH - 1 : list_len;
    if ($urandom_range(0, 9) == 0) pos = ADDR_W'($urandom);
    else if (op == OP_INSERT_AT) pos = ADDR_W'($urandom_range(0, top));
    else if (list_len > 0) pos = ADDR_W'($urandom_range(0, list_len - 1));
    else pos = ADDR_W'($urandom);
    val = pick_value();
    if (op == OP_SEARCH && list_len > 0 && $urandom_range(0, 9) < 6)
      val = list_mem[$urandom_range(0, list_len - 1)];
    send_request(op, pos, val);
  endtask

  task automatic test_directed_ops();
    send_request(OP_SEARCH, 6'd0, 32'h0000_0000);
    send_request(OP_REMOVE, 6'd0, 32'h0000_0000);
    send_request(OP_REPLACE, 6'd0, 32'h0000_0001);
    send_request(OP_INSERT_AT, 6'd1, 32'h0000_0001);
    send_request(OP_INSERT_FIRST, 6'd0, 32'h7FFF_FFFF);
    send_request(OP_INSERT_END, 6'd63, 32'h8000_0000);
    send_request(OP_INSERT_FIRST, 6'd0, 32'hFFFF_FFFF);
    send_request(OP_INSERT_AT, 6'd1, 32'h0000_0000);
    send_request(OP_INSERT_AT, 6'd4, 32'h0000_0001);
    send_request(OP_INSERT_AT, 6'd63, 32'h0000_0002);
    send_request(OP_SEARCH, 6'd0, 32'h7FFF_FFFF);
    send_request(OP_SEARCH, 6'd0, 32'h0001_2345);
    send_request(OP_REPLACE, 6'd0, 32'h0000_0000);
    send_request(OP_SEARCH, 6'd63, 32'h0000_0000);
    send_request(OP_REPLACE, 6'd5, 32'h0000_0003);
    send_request(OP_REMOVE, 6'd0, 32'h0000_0000);
    send_request(OP_REMOVE, 6'd63, 32'h0000_0000);
    send_request(OP_RSVD_A, 6'd63, 32'hFFFF_FFFF);
    send_request(OP_RSVD_B, 6'd0, 32'h0000_0000);
  endtask

  task automatic test_limit_corners();
    write_limit(7'd3);
    send_request(OP_INSERT_END, 6'd0, 32'h0000_0010);
    send_request(OP_INSERT_AT, 6'd2, 32'h0000_0011);
    send_request(OP_INSERT_AT, 6'd3, 32'h0000_0012);
    send_request(OP_INSERT_FIRST, 6'd0, 32'h0000_0013);
    send_request(OP_REMOVE, 6'd0, 32'h0000_0000);
    send_request(OP_INSERT_END, 6'd0, 32'h0000_0014);
    write_limit(7'd0);
    send_request(OP_INSERT_AT, 6'd0, 32'h0000_0015);
    send_request(OP_INSERT_END, 6'd0, 32'h0000_0016);
    send_request(OP_SEARCH, 6'd0, 32'h0000_0001);
  endtask

  task automatic test_full_depth();
    write_limit(7'd64);
    while (list_len < DEPTH - 1) send_request(OP_INSERT_END, 6'd0, pick_value());
    send_request(OP_INSERT_AT, 6'd63, 32'h7FFF_FFFF);
    send_request(OP_INSERT_END, 6'd0, 32'h0000_0001);
    send_request(OP_INSERT_FIRST, 6'd0, 32'h0000_0002);
    send_request(OP_INSERT_AT, 6'd63, 32'h0000_0003);
    send_request(OP_SEARCH, 6'd0, 32'h7FFF_FFFF);
    send_request(OP_REMOVE, 6'd63, 32'h0000_0000);
    send_request(OP_REPLACE, 6'd62, 32'h8000_0000);
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int insert_w,
                           input int remove_w, input int n_items);
    int n;
    write_limit(limit);
    for (n = 0; n < n_items; n++) random_request(insert_w, remove_w);
  endtask

  task automatic test_random_phases();
    run_phase(7'd127, 50, 15, 200);
    run_phase(LIMIT_W'($urandom_range(3, 40)), 35, 30, 140);
    gaps_on = 1'b0;
    run_phase(7'd64, 50, 15, 170);
    gaps_on = 1'b1;
    run_phase(7'd0, 35, 30, 60);
    run_phase(7'd1, 35, 30, 120);
    run_phase(7'd2, 35, 30, 100);
    run_phase(7'd100, 20, 45, 160);
    run_phase(LIMIT_W'($urandom_range(1, 64)), 35, 30, 150);
    run_phase(7'd64, 50, 15, 180);
    run_phase(7'd64, 20, 45, 170);
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    operation    = OP_INSERT_AT;
    position     = '0;
    item_value   = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    list_len     = 0;
    list_limit_q = 7'd64;
    error_count  = 0;
    cycle_count  = 0;
    gaps_on      = 1'b1;
    foreach (list_mem[i]) list_mem[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_ops();
    test_limit_corners();
    test_full_depth();
    test_random_phases();

    drain_requests();
    repeat (DEPTH + 8) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
